FILE: src/ffba_pkg.sv
// Package for the first-fit block allocator: payload structs, status and state codes,
// sizing constants. No dependencies.
`default_nettype none
package ffba_pkg;
  localparam int unsigned BLOCK_BYTES_DEF  = 64;
  localparam int unsigned NUM_BLOCKS_DEF   = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned WORD_BITS        = 32;

  typedef struct packed {
    logic        kind;
    logic [19:0] size_bytes;
    logic [31:0] address;
  } ffba_in_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } ffba_out_t;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FCHK, S_FREAD, S_FREL, S_DONE
  } ffba_state_t;
endpackage
`default_nettype wire

FILE: src/first_fit_block_allocator_top.sv
// First-fit block allocator, top level: sequencer, block-used word RAM, segment tables.
// Depends on ffba_pkg and ffba_ram.
//
//  channel | signals                  | direction
//  in      | in_valid, in_ready, in_data   | request in
//  out     | out_valid, out_ready, out_data| result out
//  cfg     | cfg_we, cfg_data             | heap_base write
//
// After reset a clearing pass runs over every block. The used map words are cleared at
// its start and the start flags over the whole pass. No request is taken.
// Allocate: the scan tests one block per cycle, pausing at each 32-block word for its read.
// Marking then reads and writes each word of the segment in turn.
// Free: the address is checked, then the start flag and length are read, and each word of
// the segment is released by read-modify-write.
// A result waits in the output register; a new request is taken once it leaves.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int unsigned BLOCK_BYTES  = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned NUM_BLOCKS   = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ffba_pkg::ffba_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ffba_pkg::ffba_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data
);
  import ffba_pkg::*;

  localparam int unsigned NW    = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WB    = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned BB    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CB    = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SHB   = $clog2(BLOCK_BYTES);
  localparam int unsigned TOT   = 22;  // size + header + block_bytes fits
  localparam int unsigned WAW   = (NW > 1) ? $clog2(NW) : 1;

  ffba_state_t state, state_next;
  logic [31:0] heap_base;
  ffba_in_t    req;
  logic [CB-1:0] need, run;
  logic [BB-1:0] first;
  logic [CB:0]   blk;     // current block being marked/released, range counter
  logic [CB-1:0] left;
  logic [BB:0]   clr;
  logic          mark_val;

  // used-map RAM
  logic              um_we;
  logic [WAW-1:0]    um_waddr, um_raddr;
  logic [31:0]       um_wdata, um_rdata;
  ffba_ram #(.WIDTH(32), .DEPTH(NW)) u_used (
    .clk, .we(um_we), .waddr(um_waddr), .wdata(um_wdata), .raddr(um_raddr), .rdata(um_rdata));

  // segment length RAM
  logic          sl_we;
  logic [BB-1:0] sl_addr_r;
  logic [CB-1:0] sl_rdata;
  ffba_ram #(.WIDTH(CB), .DEPTH(NUM_BLOCKS)) u_len (
    .clk, .we(sl_we), .waddr(first), .wdata(need), .raddr(sl_addr_r), .rdata(sl_rdata));

  // start flag RAM (cleared by pass)
  logic          sf_we, sf_wdata, sf_rdata;
  logic [BB-1:0] sf_waddr;
  ffba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_start (
    .clk, .we(sf_we), .waddr(sf_waddr), .wdata(sf_wdata), .raddr(sl_addr_r), .rdata(sf_rdata));

  // scan: word index and bit pipeline
  logic [WB:0]   widx;       // word being requested
  logic          rd_pend;    // rdata valid for word widx-1
  logic [4:0]    bidx;
  logic [31:0]   word;
  logic          word_ok;

  // free address decode
  logic [31:0] off;
  logic        fbad;
  logic [31:0] fidx;
  assign off  = req.address - heap_base - 32'(HEADER_BYTES);
  assign fidx = off >> SHB;
  assign fbad = (off[SHB-1:0] != '0) || (fidx >= 32'(NUM_BLOCKS));

  logic [TOT-1:0] total;
  logic [TOT-1:0] need_w;
  assign total  = TOT'(in_data.size_bytes) + TOT'(HEADER_BYTES) + TOT'(BLOCK_BYTES - 1);
  assign need_w = total >> SHB;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr == (BB+1)'(NUM_BLOCKS - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid && in_ready)
        state_next = (in_data.kind == KIND_FREE) ? S_FCHK : S_SCAN;
      S_SCAN:  if (run == need) state_next = S_MARK;
               else if (!word_ok && widx == (WB+1)'(NW) && !rd_pend) state_next = S_DONE;
      S_MARK:  if (left == '0) state_next = S_DONE;
      S_FCHK:  state_next = (req.address == '0 || fbad) ? S_DONE : S_FREAD;
      S_FREAD: state_next = (sf_rdata) ? S_FREL : S_DONE;
      S_FREL:  if (left == '0) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Read-modify-write of the used map, one word at a time; sl_addr_r picks start flag
  logic [WAW-1:0] blk_w;
  logic [4:0]     blk_b;
  logic [31:0]    rmw_mask;
  logic [5:0]     span;
  assign blk_w = WAW'(blk >> 5);
  assign blk_b = blk[4:0];
  always_comb begin
    span = ((6'd32 - {1'b0, blk_b}) > 6'(left)) && (left < CB'(32)) ? 6'(left)
           : 6'd32 - {1'b0, blk_b};
    rmw_mask = ((span == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << span) - 32'd1)) << blk_b;
  end

  // Marking and releasing need the word read first: two-phase sub-step
  logic rmw_ph;

  always_comb begin
    um_we = 1'b0; um_waddr = blk_w; um_wdata = '0; um_raddr = blk_w;
    sf_we = 1'b0; sf_waddr = first; sf_wdata = 1'b0;
    sl_we = 1'b0;
    unique case (state)
      S_CLEAR: begin
        um_we = (clr < (BB+1)'(NW)); um_waddr = WAW'(clr); um_wdata = '0;
        sf_we = 1'b1; sf_waddr = BB'(clr); sf_wdata = 1'b0;
      end
      S_SCAN: um_raddr = WAW'(widx);
      S_MARK, S_FREL: begin
        um_we = rmw_ph && left != '0;
        um_wdata = mark_val ? (um_rdata | rmw_mask) : (um_rdata & ~rmw_mask);
        if (state == S_MARK && left == need && rmw_ph) begin
          sf_we = 1'b1; sf_wdata = 1'b1; sl_we = 1'b1;
        end
        if (state == S_FREL && !rmw_ph && left != '0 && blk == (CB+1)'(first)) begin
          sf_we = 1'b1; sf_wdata = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; heap_base <= '0; out_valid <= 1'b0; clr <= '0; rmw_ph <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) heap_base <= cfg_data;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          out_data <= '{result_address: '0, status: ST_NOSPACE};
          widx <= '0; rd_pend <= 1'b0; word_ok <= 1'b0; bidx <= '0; run <= '0;
          rmw_ph <= 1'b0; mark_val <= (in_data.kind == KIND_ALLOC);
          if (need_w == '0) need <= CB'(1);
          else if (need_w > TOT'(NUM_BLOCKS)) need <= CB'(NUM_BLOCKS + 1) == '0 ? '1 : '1;
          else need <= CB'(need_w);
        end
        S_SCAN: begin
          if (need > CB'(NUM_BLOCKS) || need == '0) begin
            widx <= (WB+1)'(NW); rd_pend <= 1'b0; word_ok <= 1'b0;
          end else begin
            if (!word_ok && rd_pend) begin word <= um_rdata; word_ok <= 1'b1; bidx <= '0; end
            rd_pend <= !word_ok && !rd_pend && widx < (WB+1)'(NW);
            if (!word_ok && !rd_pend && widx < (WB+1)'(NW)) widx <= widx + 1'b1;
            if (word_ok && run != need) begin
              // one block per cycle within the word; last word may be partial
              if (((32'(widx) - 1) * 32 + 32'(bidx)) >= 32'(NUM_BLOCKS)) word_ok <= 1'b0;
              else begin
                if (word[bidx]) run <= '0;
                else begin
                  run <= run + 1'b1;
                  if (run + 1'b1 == need)
                    first <= BB'(((32'(widx) - 1) * 32 + 32'(bidx)) + 1 - 32'(need));
                end
                bidx <= bidx + 1'b1;
                if (bidx == 5'd31) word_ok <= 1'b0;
              end
            end
          end
          if (run == need) begin
            blk <= (CB+1)'(first); left <= need; rmw_ph <= 1'b0;
            out_data.result_address <= heap_base + (32'(first) << SHB) + 32'(HEADER_BYTES);
            out_data.status <= ST_OK;
          end
        end
        S_MARK, S_FREL: if (left != '0) begin
          rmw_ph <= !rmw_ph;
          if (rmw_ph) begin
            blk <= blk + (CB+1)'(span); left <= left - CB'(span);
          end
        end
        S_FCHK: begin
          out_data.result_address <= '0;
          out_data.status <= (req.address == '0) ? ST_NULL : ST_INVALID;
          first <= BB'(fidx);
        end
        S_FREAD: if (sf_rdata) begin
          out_data.status <= ST_OK; blk <= (CB+1)'(first); left <= sl_rdata; rmw_ph <= 1'b0;
        end
        S_DONE: if (!out_valid || out_ready) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // read address of start flag / length: FCHK presents decoded block index
  always_comb sl_addr_r = (state == S_FCHK) ? BB'(fidx) : first;

  logic unused;
  assign unused = ^{sf_waddr, total[SHB-1:0]};
endmodule
`default_nettype wire

FILE: src/ffba_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: dv/first_fit_block_allocator_top_tb.sv
// Self-checking testbench for first_fit_block_allocator_top: allocate/free requests
// against a behavioural heap map, results compared in order. Depends on ffba_pkg and first_fit_block_allocator_top.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_top_tb;
  import ffba_pkg::*;

  localparam int unsigned BLK  = BLOCK_BYTES_DEF;
  localparam int unsigned NBLK = NUM_BLOCKS_DEF;
  localparam int unsigned HDR  = HEADER_BYTES_DEF;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffba_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffba_out_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  first_fit_block_allocator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // heap model
  logic [31:0] heap_base_m;
  bit          used_m [NBLK];
  bit          start_m [NBLK];
  int unsigned seglen_m [NBLK];
  logic [31:0] live_addrs [$];

  ffba_in_t  pending_reqs [$];
  ffba_out_t awaited_results [$];
  int  errors = 0;
  int  n_results = 0, n_ok_alloc = 0, n_ok_free = 0, n_nospace = 0, n_invalid = 0;
  int  send_idle_pct = 11, recv_idle_pct = 76;
  longint cycles = 0;

  function automatic ffba_out_t predict_heap(ffba_in_t r);
    ffba_out_t o;
    longint need, run, first;
    logic [31:0] off, idx;
    o = '0;
    if (r.kind == KIND_ALLOC) begin
      need = (longint'(r.size_bytes) + HDR + BLK - 1) / BLK;
      if (need == 0) need = 1;
      o.status = ST_NOSPACE;
      run = 0;
      if (need <= NBLK) begin
        for (int i = 0; i < NBLK; i++) begin
          if (used_m[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == need) begin
              first = i + 1 - need;
              for (longint k = first; k <= i; k++) used_m[k] = 1'b1;
              start_m[first] = 1'b1;
              seglen_m[first] = 32'(need);
              o.result_address = heap_base_m + 32'(first * BLK) + 32'(HDR);
              o.status = ST_OK;
              break;
            end
          end
        end
      end
    end else if (r.address == 32'd0) begin
      o.status = ST_NULL;
    end else begin
      off = r.address - heap_base_m - 32'(HDR);
      idx = off / BLK;
      o.status = ST_INVALID;
      if (off % BLK == 0 && idx < NBLK && start_m[idx]) begin
        for (int unsigned k = 0; k < seglen_m[idx] && idx + k < NBLK; k++)
          used_m[idx + k] = 1'b0;
        start_m[idx] = 1'b0;
        o.status = ST_OK;
      end
    end
    return o;
  endfunction

  // queue a request; live allocations are tracked by the monitor for well-formed frees
  task automatic push_req(logic kind, logic [19:0] sz, logic [31:0] addr);
    ffba_in_t r;
    r.kind = kind; r.size_bytes = sz; r.address = addr;
    pending_reqs.push_back(r);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(predict_heap(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && out_ready) begin
      ffba_out_t e;
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: addr %h status %0d",
               out_data.result_address, out_data.status);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        if (out_data.result_address !== e.result_address) begin
          $error("result_address expected %h actual %h", e.result_address,
                 out_data.result_address);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
        if (e.status == ST_OK && e.result_address != 0) begin
          // ok alloc: remember address for later frees
          live_addrs.push_back(e.result_address);
          n_ok_alloc++;
        end else if (e.status == ST_OK) n_ok_free++;
        else if (e.status == ST_NOSPACE) n_nospace++;
        else if (e.status == ST_INVALID) n_invalid++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // checked at the falling edge, once the driver and monitor have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0);
    @(posedge clk);
  endtask

  // ok allocations whose address wrapped to zero never land in live_addrs
  task automatic set_base(logic [31:0] b);
    drain();
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= b;
    heap_base_m = b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: mostly live allocs and frees of returned addresses
  task automatic random_phase(int n);
    int pick;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() >= 4) @(posedge clk);
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(9) == 0) push_req(KIND_ALLOC, 20'($urandom), $urandom);
        else push_req(KIND_ALLOC, 20'($urandom_range(1500)), $urandom);
      end else if (pick < 85 && live_addrs.size() > 0) begin
        // a double free now and then
        a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        push_req(KIND_FREE, 20'($urandom), a);
        if ($urandom_range(4) != 0) begin
          foreach (live_addrs[j]) if (live_addrs[j] == a) begin
            live_addrs.delete(j);
            break;
          end
        end
      end else if (pick < 92) begin
        push_req(KIND_FREE, 20'($urandom),
                 heap_base_m + 32'(HDR) + 32'($urandom_range(NBLK + 4) * BLK));
      end else if (pick < 96) begin
        push_req(KIND_FREE, 20'($urandom), 32'd0);
      end else begin
        push_req(KIND_FREE, 20'($urandom), $urandom);
      end
      @(posedge clk);
    end
  endtask

  task automatic free_all();
    while (live_addrs.size() > 0) push_req(KIND_FREE, 20'($urandom), live_addrs.pop_front());
    drain();
  endtask

  initial begin
    heap_base_m = '0;
    foreach (used_m[i]) begin
      used_m[i] = 1'b0; start_m[i] = 1'b0; seglen_m[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, null and invalid frees, exact fit, too large, zero length
    set_base(32'h0000_1000);
    push_req(KIND_ALLOC, 20'd0, 32'hFFFF_FFFF);
    push_req(KIND_ALLOC, 20'd40, '0);
    push_req(KIND_ALLOC, 20'd41, '0);
    push_req(KIND_ALLOC, 20'hF_FFFF, '0);
    push_req(KIND_ALLOC, 20'(NBLK * BLK - HDR + 1), '0);
    push_req(KIND_FREE, 20'hF_FFFF, 32'd0);
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR) + 32'd1);
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR));
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR));
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR) + 32'(NBLK * BLK));
    push_req(KIND_FREE, '0, 32'hFFFF_FFFF);
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR) + 32'(2 * BLK));
    push_req(KIND_ALLOC, 20'(NBLK * BLK - HDR), '0);
    push_req(KIND_ALLOC, 20'd1, '0);
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR) + 32'(BLK));
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR) + 32'(2 * BLK));
    push_req(KIND_ALLOC, 20'(NBLK * BLK - HDR), '0);
    drain();
    live_addrs.delete();
    push_req(KIND_FREE, '0, 32'h0000_1000 + 32'(HDR));
    drain();

    random_phase(700);
    free_all();
    set_base(32'hFFFF_FFFF - 32'(HDR) - 32'(3 * BLK) + 32'd1);  // wraps to null
    send_idle_pct = 76; recv_idle_pct = 11;
    random_phase(650);
    free_all();
    set_base(32'hFFFF_FFC0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(650);
    free_all();
    set_base(32'h0);
    push_req(KIND_ALLOC, 20'd5, '0);
    drain();
    repeat (200) @(posedge clk);

    $display("%0d results: %0d ok allocs, %0d ok frees, %0d no-space, %0d invalid frees",
             n_results, n_ok_alloc, n_ok_free, n_nospace, n_invalid);
    $display("heap bases swept: low, near wrap, top, zero; three idle profiles");
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
src/ffba_pkg.sv
src/ffba_ram.sv
src/first_fit_block_allocator_top.sv
dv/first_fit_block_allocator_top_tb.sv
